FILE: hdl/rotated_box_geometry_decode_assert.svh
// Assertion macros for the rotated box geometry decoder
`ifndef ROTATED_BOX_GEOMETRY_DECODE_ASSERT_SVH
`define ROTATED_BOX_GEOMETRY_DECODE_ASSERT_SVH
// implication checked every clock outside reset
`define RBGD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RBGD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/rbgd_pkg.sv
// ----------------------------------------------------------------------------
// rbgd_pkg
// Shared types and constants of the rotated box geometry decoder.
// ----------------------------------------------------------------------------
package rbgd_pkg;
    localparam int CordicSteps = 16;
    localparam int AngW = 20;
    localparam int CsW = 20;
    localparam logic signed [AngW-1:0] PiQ16 = 20'sd205887;
    localparam logic signed [AngW-1:0] HalfPiQ16 = 20'sd102944;
    localparam logic signed [CsW-1:0] GainQ16 = 20'sd39797;
    localparam int CoordW = 20;

    function automatic logic signed [AngW-1:0] atan_q16(input logic [3:0] i);
        logic signed [AngW-1:0] r;
        case (i)
            4'd0: r = 20'sd51472;
            4'd1: r = 20'sd30386;
            4'd2: r = 20'sd16055;
            4'd3: r = 20'sd8150;
            4'd4: r = 20'sd4091;
            4'd5: r = 20'sd2047;
            4'd6: r = 20'sd1024;
            4'd7: r = 20'sd512;
            4'd8: r = 20'sd256;
            4'd9: r = 20'sd128;
            4'd10: r = 20'sd64;
            4'd11: r = 20'sd32;
            4'd12: r = 20'sd16;
            4'd13: r = 20'sd8;
            4'd14: r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

    // classified item handed from front to back
    typedef struct packed {
        logic [15:0] score;
        logic [15:0] d0;
        logic [15:0] d1;
        logic [15:0] d2;
        logic [15:0] d3;
        logic signed [AngW-1:0] ang;
        logic neg;
        logic [11:0] row;
        logic [11:0] col;
    } rbgd_item_t;

    typedef struct packed {
        logic [15:0] score;
        logic signed [CoordW-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
    } rbgd_res_t;
endpackage

FILE: hdl/rbgd_front.sv
// ----------------------------------------------------------------------------
// rbgd_front
// Threshold and range filter; folds the angle into plus or minus pi/2.
// ----------------------------------------------------------------------------
module rbgd_front #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          thresh,
    input  logic [15:0]          score,
    input  logic [15:0]          d0, d1, d2, d3,
    input  logic signed [14:0]   ang,
    input  logic [9:0]           row,
    input  logic [9:0]           col,
    output logic                 f_valid,
    input  logic                 f_ready,
    output rbgd_pkg::rbgd_item_t f_item
);
    import rbgd_pkg::*;
    logic valid_reg;
    rbgd_item_t item_reg, item_next;
    logic keep;
    logic signed [AngW-1:0] a16;

    assign s_tready = !valid_reg || f_ready;
    assign keep = (score > thresh) && ({3'b0, row} < 13'(MAX_ROWS))
                  && ({3'b0, col} < 13'(MAX_COLS));

    always_comb begin
        a16 = AngW'(ang) <<< 3;
        item_next.score = score;
        item_next.d0 = d0;
        item_next.d1 = d1;
        item_next.d2 = d2;
        item_next.d3 = d3;
        item_next.row = {2'b0, row};
        item_next.col = {2'b0, col};
        item_next.neg = 1'b0;
        item_next.ang = a16;
        if (a16 > HalfPiQ16) begin
            item_next.ang = a16 - PiQ16;
            item_next.neg = 1'b1;
        end else if (a16 < -HalfPiQ16) begin
            item_next.ang = a16 + PiQ16;
            item_next.neg = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid && keep;
        end
        if (s_tready && s_tvalid && keep) begin
            item_reg <= item_next;
        end
    end
    assign f_valid = valid_reg;
    assign f_item = item_reg;
endmodule

FILE: hdl/rbgd_fifo.sv
// ----------------------------------------------------------------------------
// rbgd_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rbgd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  rbgd_pkg::rbgd_item_t i_item,
    output logic                 o_valid,
    input  logic                 o_ready,
    output rbgd_pkg::rbgd_item_t o_item
);
    import rbgd_pkg::*;
    rbgd_item_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign i_ready = cnt_reg != 2'd2;
    assign o_valid = cnt_reg != 2'd0;
    assign wr = i_valid && i_ready;
    assign rd = o_valid && o_ready;
    assign o_item = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= i_item;
    end
endmodule

FILE: hdl/rbgd_back.sv
// ----------------------------------------------------------------------------
// rbgd_back
// Pipelined CORDIC, corner products, rounding, origin add and saturation.
// ----------------------------------------------------------------------------
module rbgd_back #(
    parameter int GRID_STRIDE = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  rbgd_pkg::rbgd_item_t i_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rbgd_pkg::rbgd_res_t  m_res
);
    import rbgd_pkg::*;
    localparam int NS = CordicSteps + 4;
    logic adv;
    logic vld_reg [NS];
    rbgd_item_t it_reg [CordicSteps+1];
    logic signed [CsW-1:0] x_reg [CordicSteps+1];
    logic signed [CsW-1:0] y_reg [CordicSteps+1];
    logic signed [AngW-1:0] z_reg [CordicSteps+1];
    // stage after CORDIC: c, s and item
    logic signed [CsW-1:0] c_reg, s_reg;
    rbgd_item_t ip_reg;
    // product stage
    logic signed [37:0] p_reg [8];
    logic [15:0] sc_reg;
    logic [11:0] row_reg, col_reg;
    rbgd_res_t res_reg;

    assign adv = !vld_reg[NS-1] || m_ready;
    assign i_ready = adv;
    assign m_valid = vld_reg[NS-1];
    assign m_res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) vld_reg[k] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= i_valid;
            for (int k = 1; k < NS; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it_reg[0] <= i_item;
            x_reg[0] <= GainQ16;
            y_reg[0] <= '0;
            z_reg[0] <= i_item.ang;
        end
    end

    for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (adv) begin
                it_reg[g+1] <= it_reg[g];
                if (z_reg[g] >= 0) begin
                    x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] - atan_q16(4'(g));
                end else begin
                    x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] + atan_q16(4'(g));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ip_reg <= it_reg[CordicSteps];
            c_reg <= it_reg[CordicSteps].neg ? -x_reg[CordicSteps] : x_reg[CordicSteps];
            s_reg <= it_reg[CordicSteps].neg ? -y_reg[CordicSteps] : y_reg[CordicSteps];
        end
    end

    // products: d * coefficient, all signed 17 x 20 bits
    logic signed [16:0] dm3, dp1, dm0, dp2;
    assign dm3 = -$signed({1'b0, ip_reg.d3});
    assign dp1 = $signed({1'b0, ip_reg.d1});
    assign dm0 = -$signed({1'b0, ip_reg.d0});
    assign dp2 = $signed({1'b0, ip_reg.d2});

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= 38'(dm3 * c_reg);  p_reg[1] <= 38'(dm3 * s_reg);
            p_reg[2] <= 38'(dp1 * c_reg);  p_reg[3] <= 38'(dp1 * s_reg);
            p_reg[4] <= 38'(dm0 * c_reg);  p_reg[5] <= 38'(dm0 * s_reg);
            p_reg[6] <= 38'(dp2 * c_reg);  p_reg[7] <= 38'(dp2 * s_reg);
            sc_reg <= ip_reg.score;
            row_reg <= ip_reg.row;
            col_reg <= ip_reg.col;
        end
    end

    function automatic logic signed [CoordW-1:0] crd(input logic signed [37:0] a,
                                                    input logic signed [37:0] b,
                                                    input logic [11:0] org);
        logic signed [39:0] v;
        v = ((40'(a) + 40'(b) + 40'sd32768) >>> 16)
            + $signed({28'd0, org} * 40'(GRID_STRIDE * 16));
        if (v > 40'sd524287) return 20'sd524287;
        if (v < -40'sd524288) return -20'sd524288;
        return v[CoordW-1:0];
    endfunction

    // x = px*c + py*s ; y = -px*s + py*c
    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg.score <= sc_reg;
            res_reg.c0x <= crd(p_reg[0], p_reg[5], col_reg);
            res_reg.c0y <= crd(-p_reg[1], p_reg[4], row_reg);
            res_reg.c1x <= crd(p_reg[2], p_reg[5], col_reg);
            res_reg.c1y <= crd(-p_reg[3], p_reg[4], row_reg);
            res_reg.c2x <= crd(p_reg[2], p_reg[7], col_reg);
            res_reg.c2y <= crd(-p_reg[3], p_reg[6], row_reg);
            res_reg.c3x <= crd(p_reg[0], p_reg[7], col_reg);
            res_reg.c3y <= crd(-p_reg[1], p_reg[6], row_reg);
        end
    end
endmodule

FILE: hdl/rotated_box_geometry_decode.sv
// ----------------------------------------------------------------------------
// rotated_box_geometry_decode
// Rotated text box decoder: one feature-map cell in, zero or one box out.
// ----------------------------------------------------------------------------
// Accepts one cell beat per clock while s_tready is high. Cells whose score
// does not strictly exceed the score threshold, or whose row/column lie
// outside MAX_ROWS/MAX_COLS, are dropped in the front stage. Kept cells pass a
// two-entry queue into a fully pipelined back end (16-stage CORDIC, sign-fix
// stage, product stage, round/offset/saturate stage), so sustained rate is one
// cell per cycle without output stalls. A cell reaches m_tvalid through the
// front register, queue and back end; queued cells add delay. Output stalls
// stall the back end as a whole; the queue then fills before s_tready falls.
module rotated_box_geometry_decode #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024,
    parameter int GRID_STRIDE = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,     // score threshold, Q0.16
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] cell_score, [31:16] dist_top, [47:32] dist_right,
    // [63:48] dist_bottom, [79:64] dist_left, [94:80] rot_angle,
    // [104:95] cell_row, [114:105] cell_col, rest zero
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] out_score, then corner0_x,y .. corner3_x,y, 20 bits each
    output logic [175:0] m_tdata
);
    import rbgd_pkg::*;
    logic [15:0] thresh_reg;
    logic fv, fr, qv, qr;
    rbgd_item_t fi, qi;
    rbgd_res_t res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= 16'd62259;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    rbgd_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .thresh(thresh_reg),
        .score(s_tdata[15:0]), .d0(s_tdata[31:16]), .d1(s_tdata[47:32]),
        .d2(s_tdata[63:48]), .d3(s_tdata[79:64]), .ang($signed(s_tdata[94:80])),
        .row(s_tdata[104:95]), .col(s_tdata[114:105]),
        .f_valid(fv), .f_ready(fr), .f_item(fi));

    rbgd_fifo u_fifo (.aclk, .aresetn, .i_valid(fv), .i_ready(fr), .i_item(fi),
        .o_valid(qv), .o_ready(qr), .o_item(qi));

    rbgd_back #(.GRID_STRIDE(GRID_STRIDE)) u_back (.aclk, .aresetn,
        .i_valid(qv), .i_ready(qr), .i_item(qi),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res));

    assign m_tdata = {res.c3y, res.c3x, res.c2y, res.c2x, res.c1y, res.c1x,
                      res.c0y, res.c0x, res.score};
endmodule

FILE: hdl/rbgd_checker.sv
// ----------------------------------------------------------------------------
// rbgd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotated_box_geometry_decode_assert.svh"
module rbgd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         cfg_ready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [175:0] m_tdata
);
    `RBGD_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RBGD_ASSERT_IMP(a_cfg, aclk, aresetn, 1'b1, cfg_ready)
    `RBGD_ASSERT_NXT(a_rst, aclk, 1'b1, !aresetn, !m_tvalid)
endmodule

bind rotated_box_geometry_decode rbgd_checker u_chk (.aclk, .aresetn, .cfg_ready,
    .m_tvalid, .m_tready, .m_tdata);

FILE: verif/tb_rotated_box_geometry_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotated_box_geometry_decode
// Self-checking bench for the rotated text box decoder.
// ----------------------------------------------------------------------------
// Cell beats go in with random gaps and the box port is stalled at random. A
// local fixed-point model (CORDIC sine/cosine, rounding, saturation) predicts
// each box, and every output beat is compared field by field with the oldest
// expected box. The score threshold is rewritten between phases while idle.
module tb_rotated_box_geometry_decode;
    import rbgd_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles = 60;

    typedef struct {
        logic [15:0] score;
        logic signed [19:0] cx [4];
        logic signed [19:0] cy [4];
    } box_t;

    // mismatch reporting
    int n_errors = 0;
    task automatic report_mismatch(input string what);
        n_errors++;
        $display("MISMATCH %s at %0t", what, $realtime);
    endtask

    // ------------------------------------------------------------------------
    // Box predictor and store of expected boxes
    // ------------------------------------------------------------------------
    class box_scoreboard;
        logic [15:0] threshold;
        box_t pending_boxes[$];

        function new();
            threshold = 16'd62259;
        endfunction

        static function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        static function void sincos(longint ang, output longint c, output longint s);
            longint x, y, z, xs, ys;
            bit neg;
            longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                     512, 256, 128, 64, 32, 16, 8, 4, 2};
            neg = 0;
            if (ang > 102944) begin
                ang -= 205887;
                neg = 1;
            end else if (ang < -102944) begin
                ang += 205887;
                neg = 1;
            end
            x = 39797;
            y = 0;
            z = ang;
            for (int i = 0; i < 16; i++) begin
                xs = floor_shr(x, i);
                ys = floor_shr(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end else begin
                    x += ys; y -= xs; z += atan_tab[i];
                end
            end
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        static function logic signed [19:0] corner(longint org, longint a, longint b,
                                                   longint ka, longint kb);
            longint v;
            v = floor_shr(a * ka + b * kb + 32768, 16) + org;
            if (v > 524287) v = 524287;
            if (v < -524288) v = -524288;
            return v[19:0];
        endfunction

        // note one accepted cell beat
        function void note_cell(logic [119:0] d);
            longint d0, d1, d2, d3, ang, c, s, ox, oy, px, py;
            box_t b;
            if (d[15:0] <= threshold) return;
            d0 = d[31:16]; d1 = d[47:32]; d2 = d[63:48]; d3 = d[79:64];
            ang = longint'($signed(d[94:80]));
            sincos(ang * 8, c, s);
            ox = longint'(d[114:105]) * 64;
            oy = longint'(d[104:95]) * 64;
            b.score = d[15:0];
            for (int k = 0; k < 4; k++) begin
                px = (k == 0 || k == 3) ? -d3 : d1;
                py = (k < 2) ? -d0 : d2;
                b.cx[k] = corner(ox, px, py, c, s);
                b.cy[k] = corner(oy, px, py, -s, c);
            end
            pending_boxes = {pending_boxes, b};
        endfunction

        // check one output beat against the oldest expected box
        task check_box(logic [175:0] d);
            box_t b;
            if (pending_boxes.size() == 0) begin
                report_mismatch("box beat with nothing expected");
                return;
            end
            b = pending_boxes.pop_front();
            if (d[15:0] !== b.score) report_mismatch("out_score");
            for (int k = 0; k < 4; k++) begin
                if (d[16 + 40*k +: 20] !== b.cx[k])
                    report_mismatch($sformatf("corner%0d_x", k));
                if (d[36 + 40*k +: 20] !== b.cy[k])
                    report_mismatch($sformatf("corner%0d_y", k));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [15:0] cfg_data = '0;
    logic s_tvalid = 0, s_tready;
    logic [119:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0;
    logic [175:0] m_tdata;

    box_scoreboard sb = new();
    int idle_cycles = 0;
    bit drive_done = 0;
    bit stall_on = 1;

    initial begin
        forever #1 aclk = ~aclk;
    end

    rotated_box_geometry_decode u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample at the rising edge: accepted cells and box beats, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_cell(s_tdata);
            if (m_tvalid && m_tready) sb.check_box(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else if (!drive_done || sb.pending_boxes.size() != 0)
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // output back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        if (!stall_on) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                         ($urandom_range(0, 3) == 0 ? 1'b0 : m_tready);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_threshold(input logic [15:0] thr);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= thr;
        do @(posedge aclk); while (!cfg_ready);
        sb.threshold = thr;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // send one cell beat; valid stays high across back-to-back beats
    task automatic send_cell(input logic [15:0] score, input logic [15:0] d0,
                             input logic [15:0] d1, input logic [15:0] d2,
                             input logic [15:0] d3, input logic [14:0] ang,
                             input logic [9:0] row, input logic [9:0] col);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, col, row, ang, d3, d2, d1, d0, score};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_boxes.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    function automatic logic [14:0] rand_angle();
        int a;
        a = $urandom_range(0, 25736);
        return 15'(a - 12868);
    endfunction

    task automatic random_cell();
        int r;
        logic [15:0] sc;
        logic [15:0] d [4];
        r = $urandom_range(0, 99);
        sc = (r < 75) ? 16'($urandom_range(sb.threshold, 65535)) : 16'($urandom);
        foreach (d[i]) d[i] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 2047));
        send_cell(sc, d[0], d[1], d[2], d[3], ($urandom_range(0, 19) == 0) ?
                  15'($urandom) : rand_angle(), 10'($urandom), 10'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset threshold, boundary scores, extreme fields, angle edges
        send_cell(16'd62259, 16'd16, 16'd16, 16'd16, 16'd16, 15'd0, 10'd1, 10'd1);
        send_cell(16'd62260, 16'd16, 16'd32, 16'd48, 16'd64, 15'd0, 10'd2, 10'd3);
        send_cell(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd12868,
                  10'd1023, 10'd1023);
        send_cell(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, -15'sd12868,
                  10'd0, 10'd0);
        send_cell(16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 15'h3FFF, 10'd0, 10'd0);
        send_cell(16'hFFFF, 16'd100, 16'd200, 16'd300, 16'd400, 15'h4000,
                  10'd512, 10'd512);
        send_cell(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 15'd6434, 10'd0, 10'd1023);
        send_cell(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, -15'sd6434, 10'd1023, 10'd0);
        send_cell(16'hFFFF, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA,
                  10'h2AA, 10'h155);
        send_cell(16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 15'h5555,
                  10'h155, 10'h2AA);
        send_cell(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 15'd1, 10'd1, 10'd1);
        wait_idle();

        // threshold extremes: zero passes all but score 0, all-ones passes none
        write_threshold(16'd0);
        send_cell(16'd0, 16'd5, 16'd5, 16'd5, 16'd5, 15'd100, 10'd9, 10'd9);
        send_cell(16'd1, 16'd5, 16'd5, 16'd5, 16'd5, 15'd100, 10'd9, 10'd9);
        for (int i = 0; i < 300; i++) random_cell();
        wait_idle();

        write_threshold(16'hFFFF);
        send_cell(16'hFFFF, 16'd5, 16'd5, 16'd5, 16'd5, 15'd100, 10'd9, 10'd9);
        for (int i = 0; i < 40; i++) random_cell();
        wait_idle();

        write_threshold(16'h8000);
        stall_on = 0;
        for (int i = 0; i < 150; i++) random_cell();
        stall_on = 1;
        for (int i = 0; i < 250; i++) random_cell();
        wait_idle();

        write_threshold(16'($urandom));
        for (int i = 0; i < 250; i++) random_cell();
        wait_idle();

        drive_done = 1;
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/rbgd_pkg.sv
hdl/rbgd_front.sv
hdl/rbgd_fifo.sv
hdl/rbgd_back.sv
hdl/rotated_box_geometry_decode.sv
hdl/rbgd_checker.sv
verif/tb_rotated_box_geometry_decode.sv
